/* rtl/fpwj_pkg.sv */
// ----------------------------------------------------------------------------
// fpwj_pkg: shared types and constants of the fragment pair window join
// Window depth, field widths, payload structs and circular slot arithmetic.
// ----------------------------------------------------------------------------
package fpwj_pkg;

  localparam int unsigned WindowDepth = 64;
  localparam int unsigned SlotW       = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned CntW        = $clog2(WindowDepth + 1);

  localparam int unsigned PosW     = 31;
  localparam int unsigned GapW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 31;

  localparam logic [PosW-1:0]  PosMax    = '1;
  localparam logic [SlotW:0]   DepthSlot = (SlotW + 1)'(WindowDepth);
  localparam logic [CntW-1:0]  DepthCnt  = CntW'(WindowDepth);

  localparam logic STRAND_FWD = 1'b0;
  localparam logic STRAND_REV = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_GAP      = 2'd0,
    CFG_MAX_GAP      = 2'd1,
    CFG_SEQ_LEN      = 2'd2,
    CFG_END_PLUS_ONE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PosW-1:0] hit_position;
    logic            hit_strand;
    logic            last_hit;
  } hit_t;

  typedef struct packed {
    logic [PosW-1:0] pair_start;
    logic [PosW-1:0] pair_end;
    logic            run_last;
    logic            window_overflow;
  } pair_t;

  typedef struct packed {
    logic [GapW-1:0] min_gap;
    logic [GapW-1:0] max_gap;
    logic [PosW-1:0] seq_len;
    logic            end_plus_one;
  } cfg_t;

  // classified hit, as handed from the front to the back
  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            strand;
    logic            last;
    logic            in_seq;
    logic [PosW-1:0] end_pos;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_chan_t;

  // (base + off) modulo the window depth; both operands below the depth
  function automatic logic [SlotW-1:0] slot_add(input logic [SlotW-1:0] base,
                                                input logic [SlotW-1:0] off);
    logic [SlotW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DepthSlot) begin
      sum = sum - DepthSlot;
    end
    return sum[SlotW-1:0];
  endfunction

endpackage

/* rtl/fpwj_front.sv */
// ----------------------------------------------------------------------------
// fpwj_front: hit intake and classification
// Takes hits, marks anchors inside the sequence, forms the reported end
// position and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module fpwj_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpwj_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fpwj_pkg::hit_t    in_data_i,
  output fpwj_pkg::job_chan_t job_o,
  input  logic              job_pop_i
);
  import fpwj_pkg::*;

  job_t        q_mem [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;
  logic        push;
  logic        pop;
  job_t        job_new;
  logic [PosW:0] end_sum;

  // end = p + end_plus_one, saturated at the largest position
  assign end_sum = {1'b0, in_data_i.hit_position} + (PosW + 1)'(cfg_i.end_plus_one);

  always_comb begin
    job_new.pos     = in_data_i.hit_position;
    job_new.strand  = in_data_i.hit_strand;
    job_new.last    = in_data_i.last_hit;
    job_new.in_seq  = in_data_i.hit_position < cfg_i.seq_len;
    job_new.end_pos = end_sum[PosW] ? PosMax : end_sum[PosW-1:0];
  end

  assign in_stall_o = (fill_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = job_pop_i && (fill_q != 2'd0);

  assign job_o.valid = (fill_q != 2'd0);
  assign job_o.job   = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= job_new;
    end
  end

endmodule

/* rtl/fpwj_back.sv */
// ----------------------------------------------------------------------------
// fpwj_back: window store, eviction and oldest-first pair scan
// Walks the forward window one entry a cycle barring output stalls, dropping
// stale anchors; pairs leave through a pending stage and an output register.
// ----------------------------------------------------------------------------
module fpwj_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpwj_pkg::cfg_t      cfg_i,
  input  fpwj_pkg::job_chan_t job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fpwj_pkg::pair_t     out_data_o
);
  import fpwj_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  logic [PosW-1:0] mem [WindowDepth];

  state_e          state_q;
  job_t            job_q;
  logic [SlotW-1:0] head_q;
  logic [CntW-1:0] count_q;
  logic            overflow_q;
  logic [CntW-1:0] ri_q;
  logic            d_valid_q;
  logic [PosW-1:0] rdata_q;
  logic            evicting_q;
  logic [CntW-1:0] evict_n_q;
  logic            pend_valid_q;
  logic [PosW-1:0] pend_q;
  logic            out_valid_q;
  pair_t           out_data_q;

  logic            out_free;
  logic [PosW:0]   p_ext;
  logic [PosW:0]   f_plus_max;
  logic [PosW:0]   f_plus_min;
  logic            evict_cond;
  logic            d_pair;
  logic            advance;
  logic            issue;
  logic            rd_en;
  logic [SlotW-1:0] rd_addr;
  logic            scan_done;
  logic            commit;
  logic            push;
  logic [SlotW-1:0] head_ev;
  logic [CntW-1:0] cnt_ev;
  logic            store;
  logic            full;
  logic            wr_en;
  logic [SlotW-1:0] wr_addr;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign p_ext      = {1'b0, job_q.pos};
  assign f_plus_max = {1'b0, rdata_q} + (PosW + 1)'(cfg_i.max_gap);
  assign f_plus_min = {1'b0, rdata_q} + (PosW + 1)'(cfg_i.min_gap);
  assign evict_cond = f_plus_max < p_ext;
  assign d_pair     = d_valid_q && (job_q.strand == STRAND_REV) &&
                      (f_plus_min < p_ext) && (p_ext <= f_plus_max);

  // a second pair needs the output register to take the pending one
  assign advance = !(d_pair && pend_valid_q && !out_free);

  // forward hits only walk until the first anchor that stays
  assign issue   = (state_q == ST_SCAN) && (ri_q < count_q) &&
                   ((job_q.strand == STRAND_REV) || evicting_q);
  assign rd_en   = issue && advance;
  assign rd_addr = slot_add(head_q, ri_q[SlotW-1:0]);

  assign scan_done = (state_q == ST_SCAN) && !d_valid_q && !issue;
  assign commit    = (state_q == ST_FINISH) && (!pend_valid_q || out_free);
  assign push      = ((state_q == ST_SCAN) && advance && d_pair && pend_valid_q) ||
                     (commit && pend_valid_q);

  assign head_ev = slot_add(head_q, evict_n_q[SlotW-1:0]);
  assign cnt_ev  = count_q - evict_n_q;
  assign store   = (job_q.strand == STRAND_FWD) && job_q.in_seq;
  assign full    = (cnt_ev == DepthCnt);
  assign wr_en   = commit && store && !full;
  assign wr_addr = slot_add(head_ev, cnt_ev[SlotW-1:0]);

  assign job_pop_o   = (state_q == ST_IDLE) && job_i.valid;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      overflow_q   <= 1'b0;
      ri_q         <= '0;
      d_valid_q    <= 1'b0;
      evicting_q   <= 1'b0;
      evict_n_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (job_i.valid) begin
            ri_q         <= '0;
            d_valid_q    <= 1'b0;
            evicting_q   <= 1'b1;
            evict_n_q    <= '0;
            pend_valid_q <= 1'b0;
            state_q      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (advance) begin
            d_valid_q <= issue;
            if (issue) begin
              ri_q <= ri_q + 1'b1;
            end
            if (d_valid_q) begin
              if (evicting_q && evict_cond) begin
                evict_n_q <= evict_n_q + 1'b1;
              end else begin
                evicting_q <= 1'b0;
              end
              if (d_pair) begin
                pend_valid_q <= 1'b1;
              end
            end
          end
          if (scan_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (commit) begin
            pend_valid_q <= 1'b0;
            if (job_q.last) begin
              head_q  <= '0;
              count_q <= '0;
            end else begin
              head_q  <= head_ev;
              count_q <= (store && !full) ? cnt_ev + 1'b1 : cnt_ev;
            end
            if (store && full) begin
              overflow_q <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i.job;
    end
    if ((state_q == ST_SCAN) && advance && d_pair) begin
      pend_q <= rdata_q;
    end
    if (push) begin
      out_data_q.pair_start      <= pend_q;
      out_data_q.pair_end        <= job_q.end_pos;
      out_data_q.run_last        <= (state_q == ST_FINISH);
      out_data_q.window_overflow <= overflow_q;
    end
  end

  // window store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= job_q.pos;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule

/* rtl/fragment_pair_window_join.sv */
// ----------------------------------------------------------------------------
// fragment_pair_window_join: joins forward and reverse read hits into pairs
// Forward hits are kept in a circular window; each reverse hit scans it and
// emits one transfer per matching anchor, oldest anchor first.
// ----------------------------------------------------------------------------
// Path: a hit enters the front queue and then the back end's job register; a
//   pair goes from the store read register through the pending stage to the
//   output register. The back end finishes one hit before it takes the next;
//   a reverse hit reads every window entry, stale or kept, a forward hit the
//   stale ones and up to two more. Output stalls hold the scan.
// Reset: asynchronous, active low; empties window and queue, clears overflow.
module fragment_pair_window_join (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [fpwj_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [fpwj_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // hit channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  fpwj_pkg::hit_t                     in_data_i,
  // pair channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output fpwj_pkg::pair_t                    out_data_o
);
  import fpwj_pkg::*;

  cfg_t      cfg_q;
  job_chan_t job_chan;
  logic      job_pop;

  // Configuration registers, reset to the defaults. Writes are expected only
  // while the block is idle, so both halves see one value for a whole item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_gap      <= '0;
      cfg_q.max_gap      <= GapW'(400);
      cfg_q.seq_len      <= PosMax;
      cfg_q.end_plus_one <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_GAP:      cfg_q.min_gap      <= cfg_wdata_i[GapW-1:0];
        CFG_MAX_GAP:      cfg_q.max_gap      <= cfg_wdata_i[GapW-1:0];
        CFG_SEQ_LEN:      cfg_q.seq_len      <= cfg_wdata_i[PosW-1:0];
        CFG_END_PLUS_ONE: cfg_q.end_plus_one <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Front: accepts hits, classifies them, queues two deep.
  fpwj_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .job_o      (job_chan),
    .job_pop_i  (job_pop)
  );

  // Back: evicts, scans the window, stores anchors, drives pair transfers.
  fpwj_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (job_chan),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/fpwj_checker.sv */
// ----------------------------------------------------------------------------
// fpwj_checker: port level checks of the fragment pair window join
// Watches the pair channel for held transfers, pair ordering and the
// sticky overflow flag.
// ----------------------------------------------------------------------------
module fpwj_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input fpwj_pkg::pair_t out_data_o
);
  import fpwj_pkg::*;

  // a stalled pair stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("pair changed while stalled");

  // the reverse end always lies past the forward start
  a_end_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pair_end > out_data_o.pair_start)
    else $error("pair end not after pair start");

  // once reported, overflow stays reported
  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.window_overflow
    |=> !out_valid_o || out_data_o.window_overflow)
    else $error("overflow flag cleared");

  // run mark in flight must stay with its pair while stalled
  a_run_last_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && out_data_o.run_last
    |=> out_data_o.run_last && out_data_o.pair_end == $past(out_data_o.pair_end))
    else $error("run end mark lost");

endmodule

bind fragment_pair_window_join fpwj_checker u_fpwj_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* tb/fragment_pair_window_join_tb.sv */
// ----------------------------------------------------------------------------
// fragment_pair_window_join_tb: self-checking bench of the pair window join
// A scoreboard predicts every pair from the accepted hits and the current
// register values, and checks each pair transfer against it field by field.
// The stimulus is a short directed part, then runs of hits under several
// register settings, with random idling and stalls and one long output hold.
// ----------------------------------------------------------------------------
module fragment_pair_window_join_tb;
  import fpwj_pkg::*;

  localparam int unsigned     HalfPeriod   = 6;
  localparam int unsigned     ResetCycles  = 8;
  // Quiet time before a register write. A queued forward hit can still be
  // dropping stale anchors after the last pair has left the block.
  localparam int unsigned     SettleCycles = 400;
  localparam int unsigned     DrainCycles  = 200;
  // Long output hold, so that the hit queue fills and the hit input stalls.
  localparam int unsigned     HoldCycles   = 500;
  localparam int unsigned     MaxReports   = 10;
  localparam longint unsigned LimitCycles  = 1_000_000;

  // --------------------------------------------------------------------------
  // Scoreboard: window of forward anchors, sticky overflow flag, register
  // copies, and the pairs that are still to arrive, oldest first.
  // --------------------------------------------------------------------------
  class pair_scoreboard;
    logic [GapW-1:0] min_gap;
    logic [GapW-1:0] max_gap;
    logic [PosW-1:0] seq_len;
    logic            end_plus_one;
    logic [PosW-1:0] anchors[$];
    logic            overflow;
    pair_t           awaited_pairs[$];
    int unsigned     mismatches;

    function new();
      min_gap      = '0;
      max_gap      = 16'd400;
      seq_len      = PosMax;
      end_plus_one = 1'b1;
      overflow     = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_config(logic [GapW-1:0] mn, logic [GapW-1:0] mx,
                             logic [PosW-1:0] sl, logic epo);
      min_gap      = mn;
      max_gap      = mx;
      seq_len      = sl;
      end_plus_one = epo;
    endfunction

    // Accepted hit: update the window and queue the pairs it makes.
    function void join_hit(hit_t h);
      logic [32:0] p;
      logic [32:0] f;
      logic [31:0] end_sum;
      pair_t       pr;
      pair_t       found[$];
      p = {2'b00, h.hit_position};
      // stale anchors leave from the oldest end, whatever the strand
      while (anchors.size() > 0 && ({2'b00, anchors[0]} + 33'(max_gap)) < p)
        void'(anchors.pop_front());
      if (h.hit_strand == STRAND_FWD) begin
        if (h.hit_position < seq_len) begin
          if (anchors.size() >= WindowDepth) begin
            overflow = 1'b1;
          end else begin
            anchors.push_back(h.hit_position);
          end
        end
      end else begin
        end_sum = {1'b0, h.hit_position} + 32'(end_plus_one);
        foreach (anchors[i]) begin
          f = {2'b00, anchors[i]};
          if ((f + 33'(min_gap)) < p && p <= (f + 33'(max_gap))) begin
            pr.pair_start      = anchors[i];
            pr.pair_end        = end_sum[PosW] ? PosMax : end_sum[PosW-1:0];
            pr.run_last        = 1'b0;
            pr.window_overflow = overflow;
            found.push_back(pr);
          end
        end
        if (found.size() > 0) found[found.size()-1].run_last = 1'b1;
        foreach (found[i]) awaited_pairs.push_back(found[i]);
      end
      if (h.last_hit) anchors.delete();
    endfunction

    function void check_pair(pair_t got);
      pair_t want;
      if (awaited_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("pair with none awaited: start %0d end %0d last %0b ovf %0b",
                   got.pair_start, got.pair_end, got.run_last, got.window_overflow);
        return;
      end
      want = awaited_pairs.pop_front();
      if (got.pair_start !== want.pair_start || got.pair_end !== want.pair_end ||
          got.run_last !== want.run_last ||
          got.window_overflow !== want.window_overflow) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display({"pair mismatch: exp start %0d end %0d last %0b ovf %0b, ",
                    "got start %0d end %0d last %0b ovf %0b"},
                   want.pair_start, want.pair_end, want.run_last,
                   want.window_overflow, got.pair_start, got.pair_end,
                   got.run_last, got.window_overflow);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  hit_t                in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  pair_t               out_data_o;

  fragment_pair_window_join DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  pair_scoreboard  sb;
  logic [PosW-1:0] cur_pos;     // position cursor of the hit stream
  int unsigned     gap_pct;     // chance per hit of a sender idle burst
  int unsigned     stall_pct;   // chance per cycle of a receiver stall burst
  bit              hold_req;    // sender asks the receiver for the long hold

  initial begin
    clk_i = 1'b0;
    forever #HalfPeriod clk_i = ~clk_i;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #(LimitCycles * 2 * HalfPeriod);
    $display("Verification failed");
    $finish;
  end

  // Monitors sample at the edge, before this edge's updates land, so the
  // transfer seen here is exactly the one the block took.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.join_hit(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_pair(out_data_o);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus the long hold when asked. The hold
  // is counted here, so the sender keeps offering hits meanwhile.
  // --------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // One hit transfer. Valid stays high after the transfer, so a following
  // hit goes out back to back unless an idle burst drops it first.
  task automatic send_hit(input logic [PosW-1:0] pos, input logic strand,
                          input logic last);
    hit_t h;
    h.hit_position = pos;
    h.hit_strand   = strand;
    h.last_hit     = last;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= h;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Registers change only with the block idle: no pair awaited, then a quiet
  // stretch for hits that make no pair but may still be in flight.
  task automatic configure(input logic [GapW-1:0] mn, input logic [GapW-1:0] mx,
                           input logic [PosW-1:0] sl, input logic epo);
    logic [CfgDataW-1:0] data;
    in_valid_i <= 1'b0;
    while (sb.awaited_pairs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    // unused upper bits carry noise; the block must ignore them
    data = CfgDataW'($urandom);
    data[GapW-1:0] = mn;
    write_reg(CFG_MIN_GAP, data);
    data = CfgDataW'($urandom);
    data[GapW-1:0] = mx;
    write_reg(CFG_MAX_GAP, data);
    write_reg(CFG_SEQ_LEN, sl);
    data = CfgDataW'($urandom);
    data[0] = epo;
    write_reg(CFG_END_PLUS_ONE, data);
    cfg_we_i <= 1'b0;
    sb.set_config(mn, mx, sl, epo);
  endtask

  // A run of hits. Steps are scaled to max_gap so that most reverse hits land
  // inside the pairing range; some jump far (eviction), some go backward and
  // some are pure noise. Dense runs crowd the window until it overflows.
  task automatic run_hits(input int unsigned n, input int unsigned fwd_pct,
                          input int unsigned last_pct, input bit dense,
                          input bit hold);
    int unsigned span;
    int unsigned r;
    logic        strand;
    logic        last;
    span = (sb.max_gap == 0) ? 1 : 32'(sb.max_gap);
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (dense) begin
        cur_pos += PosW'($urandom_range(0, 3));
      end else if (r >= 15 && r < 70) begin
        cur_pos += PosW'($urandom_range(1, span / 4 + 1));
      end else if (r >= 70 && r < 85) begin
        cur_pos += PosW'($urandom_range(1, span + 2));
      end else if (r >= 85 && r < 90) begin
        cur_pos += PosW'($urandom_range(span + 1, span + 100000));
      end else if (r >= 90 && r < 95) begin
        cur_pos -= PosW'($urandom_range(1, span / 2 + 1));
      end else if (r >= 95) begin
        cur_pos = PosW'($urandom);
      end
      if (hold && k == 12) hold_req = 1'b1;
      strand = ($urandom_range(0, 99) < fwd_pct) ? STRAND_FWD : STRAND_REV;
      last   = ($urandom_range(0, 99) < last_pct);
      send_hit(cur_pos, strand, last);
    end
  endtask

  function automatic logic [PosW-1:0] pick_seq_len();
    logic [31:0] sum;
    if ($urandom_range(0, 1) == 0) return PosMax;
    sum = {1'b0, cur_pos} + $urandom_range(0, 50000);
    if (sum[PosW]) return PosMax;
    if (sum[PosW-1:0] == '0) return PosW'(1);
    return sum[PosW-1:0];
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 40;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [GapW-1:0] mn;
    logic [GapW-1:0] mx;
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_MIN_GAP;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cur_pos     = '0;
    gap_pct     = 10;
    stall_pct   = 10;
    hold_req    = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset register values.
    configure(16'd0, 16'd400, PosMax, 1'b1);
    send_hit(31'd0, STRAND_FWD, 1'b0);
    send_hit(31'd0, STRAND_REV, 1'b0);        // distance zero: no pair
    send_hit(31'd1, STRAND_REV, 1'b0);        // smallest distance that pairs
    send_hit(31'd400, STRAND_REV, 1'b0);      // distance exactly max_gap
    send_hit(31'd401, STRAND_REV, 1'b0);      // anchor evicted first
    send_hit(31'd1000, STRAND_FWD, 1'b0);
    send_hit(31'd1000, STRAND_FWD, 1'b0);
    send_hit(31'd1200, STRAND_REV, 1'b1);     // two pairs, then window cleared
    send_hit(31'd1300, STRAND_REV, 1'b0);     // nothing left after the clear
    send_hit(PosMax - 31'd1, STRAND_FWD, 1'b0);
    send_hit(PosMax, STRAND_FWD, 1'b0);       // at sequence length: not kept
    send_hit(PosMax, STRAND_REV, 1'b0);       // end saturates
    send_hit(PosMax, STRAND_REV, 1'b1);
    send_hit(31'd500, STRAND_FWD, 1'b0);      // positions step backward
    send_hit(31'd300, STRAND_REV, 1'b0);
    send_hit(31'd600, STRAND_REV, 1'b0);
    send_hit(31'd100, STRAND_REV, 1'b1);

    // Dense forward hits under the widest gap: full window, drops, the
    // overflow flag, pairs by the dozen, and the long output hold.
    gap_pct   = 5;
    stall_pct = 10;
    configure(16'd0, 16'hFFFF, PosMax, 1'b1);
    cur_pos = PosW'($urandom);
    run_hits(110, 75, 0, 1'b1, 1'b1);

    // Widest min_gap with zero max_gap: no pair can qualify.
    configure(16'hFFFF, 16'd0, pick_seq_len(), 1'b0);
    run_hits(25, 50, 5, 1'b0, 1'b0);

    // Shortest sequence: only position zero can become an anchor.
    gap_pct   = pick_pct();
    stall_pct = pick_pct();
    configure(16'd0, 16'd3, PosW'(1), 1'b0);
    cur_pos = '0;
    run_hits(20, 50, 10, 1'b1, 1'b0);

    // Random settings.
    repeat (4) begin
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      cur_pos   = PosW'($urandom);
      mn = GapW'($urandom_range(0, 300));
      mx = ($urandom_range(0, 3) == 0) ? GapW'($urandom)
                                       : GapW'(mn + $urandom_range(0, 2000));
      configure(mn, mx, pick_seq_len(), 1'($urandom_range(0, 1)));
      run_hits(40, $urandom_range(30, 70), 4, 1'b0, 1'b0);
    end

    // Tail with no idling on either side.
    gap_pct   = 0;
    stall_pct = 0;
    mn = GapW'($urandom_range(0, 50));
    configure(mn, GapW'(mn + $urandom_range(100, 1000)), PosMax, 1'b1);
    run_hits(50, 50, 4, 1'b0, 1'b0);

    in_valid_i <= 1'b0;
    while (sb.awaited_pairs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.awaited_pairs.size() != 0)
      $display("%0d pairs never delivered", sb.awaited_pairs.size());
    if (sb.mismatches == 0 && sb.awaited_pairs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
